FILE: hdl/text_console_writer_core_macros.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared forms for the concurrent checks of the console core.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Payload types, register indexes and character codes of the console core.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CELL_W      = 16;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int FIRST_W     = 5;
    localparam int POS_W       = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_CHAR_ATTRIBUTE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_TEXT_ROW = 1'd1;

    localparam logic [CHAR_W-1:0] CODE_BS   = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_TAB  = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_LF   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_FF   = 8'd12;
    localparam logic [CHAR_W-1:0] CODE_CR   = 8'd13;
    localparam logic [CHAR_W-1:0] PRINT_LO  = 8'd32;
    localparam logic [CHAR_W-1:0] PRINT_HI  = 8'd126;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0]  ATTR_RESET      = 8'h0F;
    localparam logic [FIRST_W-1:0] FIRST_ROW_RESET = 5'd3;
    localparam logic [CELL_W-1:0]  RESET_CELL      = {ATTR_RESET, CHAR_SPACE};

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] char_code;
        logic [10:0]       cell_address;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] read_data;
    } t_out_item;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_write;

endpackage

FILE: hdl/tcw_chan_if.sv
// ----------------------------------------------------------------------------
// Text console writer channel
// Valid and ready handshake channel with a typed payload.
// ----------------------------------------------------------------------------
interface tcw_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// Text console writer core
// Text-mode console with a cell store of attribute and character and a cursor.
// ----------------------------------------------------------------------------
// Items arrive on i_in: a put writes or interprets char_code at the cursor, a
// read returns the cell at cell_address. Every item gives one result on
// o_result with the cursor position after the item and, for reads, the cell.
// Registers are written on i_cfg, which is always ready; the user must write them
// only while the core idles, and the core itself does not enforce this. A
// printable, CR, LF without scroll, BS or ignored code finishes on acceptance;
// a read finishes in ST_READ, since the cell store has a registered read port.
// TAB writes TAB_SPACES spaces. A scroll or FF walks the scrolling area one
// cell a cycle through the single write port, as part of the item that causes
// it. Input is not ready while an item is at work. After reset the store is
// cleared one cell a cycle, COLUMNS * ROWS cells, before the first item is taken.
// The result register lets the core take the next item while the previous result
// waits; finishing that item then holds the core until the receiver takes it.
// ----------------------------------------------------------------------------
`include "text_console_writer_core_macros.svh"

module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcw_chan_if.sink    i_in,
    tcw_chan_if.sink    i_cfg,
    tcw_chan_if.source  o_result
);

    localparam int CELLS         = COLUMNS * ROWS;
    localparam int ADDR_W        = $clog2(CELLS);
    localparam int ROW_W         = $clog2(ROWS);
    localparam int COL_W         = $clog2(COLUMNS);
    localparam int TAB_W         = $clog2(TAB_SPACES + 1);
    localparam int CMP_W         = (ADDR_W > 11 ? ADDR_W : 11) + 1;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_TAB,
        ST_SWEEP,
        ST_DRAIN,
        ST_HOLD
    } t_state;

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic [TAB_W-1:0]   r_tab_cnt, n_tab_cnt;
    logic               r_clear_mode, n_clear_mode;
    logic               r_after_tab, n_after_tab;
    logic               r_rd_ok, n_rd_ok;
    logic [CELL_W-1:0]  r_res_data, n_res;
    logic               r_wr_pend, n_wr_pend;
    logic [ADDR_W-1:0]  r_wr_addr, n_wr_addr;
    logic               r_wr_blank, n_wr_blank;
    logic [ATTR_W-1:0]  r_attr;
    logic [FIRST_W-1:0] r_first;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               in_accept;
    logic               slot_free;
    logic               fin;
    logic               do_step;
    logic               scroll_start;
    logic               row_last;
    logic               col_last;
    logic [ROW_W-1:0]   top_row;
    logic [ADDR_W-1:0]  top_base;
    logic [ADDR_W-1:0]  cur_addr;
    logic [CELL_W-1:0]  blank_cell;
    logic [CHAR_W-1:0]  step_char;
    logic [POS_W-1:0]   pos_full;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CELL_W-1:0]  wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CELL_W-1:0]  rd_data;

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign in_accept  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign slot_free  = !r_out_valid || o_result.ready;

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out_item;

    assign row_last   = (r_row == ROW_W'(ROWS - 1));
    assign col_last   = (r_col == COL_W'(COLUMNS - 1));
    assign top_row    = (32'(r_first) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(r_first);
    assign top_base   = ADDR_W'(32'(top_row) * COLUMNS);
    assign cur_addr   = ADDR_W'(32'(r_row) * COLUMNS + 32'(r_col));
    assign blank_cell = {r_attr, CHAR_SPACE};
    assign step_char  = (r_state == ST_TAB) ? CHAR_SPACE : i_in.payload.char_code;

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_ptr        = r_ptr;
        n_tab_cnt    = r_tab_cnt;
        n_clear_mode = r_clear_mode;
        n_after_tab  = r_after_tab;
        n_rd_ok      = r_rd_ok;
        n_res        = r_res_data;
        n_wr_pend    = 1'b0;
        n_wr_addr    = r_wr_addr;
        n_wr_blank   = r_wr_blank;
        fin          = 1'b0;
        do_step      = 1'b0;
        scroll_start = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = cur_addr;
        wr_data      = blank_cell;
        rd_en        = 1'b0;
        rd_addr      = ADDR_W'(i_in.payload.cell_address);

        // The second half of a sweep step writes a blank or the cell read the cycle before.
        if (r_wr_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_wr_addr;
            wr_data = r_wr_blank ? blank_cell : rd_data;
        end

        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = RESET_CELL;
                if (32'(r_ptr) == CELLS - 1) begin
                    n_state = ST_IDLE;
                    n_ptr   = '0;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_after_tab = 1'b0;
                    if (i_in.payload.op == OP_READ) begin
                        rd_en   = 1'b1;
                        n_rd_ok = CMP_W'(i_in.payload.cell_address) < CMP_W'(CELLS);
                        n_state = ST_READ;
                    end else begin
                        n_res = '0;
                        case (i_in.payload.char_code) inside
                            [PRINT_LO:PRINT_HI]: begin
                                do_step = 1'b1;
                            end
                            CODE_LF: begin
                                n_col = '0;
                                if (row_last) begin
                                    scroll_start = 1'b1;
                                end else begin
                                    n_row = r_row + ROW_W'(1);
                                    fin   = 1'b1;
                                end
                            end
                            CODE_CR: begin
                                n_col = '0;
                                fin   = 1'b1;
                            end
                            CODE_TAB: begin
                                n_tab_cnt   = TAB_W'(TAB_SPACES);
                                n_after_tab = 1'b1;
                                n_state     = ST_TAB;
                            end
                            CODE_BS: begin
                                // In both cases the blanked cell sits just before the cursor.
                                if (r_col != '0) begin
                                    n_col   = r_col - COL_W'(1);
                                    wr_en   = 1'b1;
                                    wr_addr = cur_addr - ADDR_W'(1);
                                end else if (r_row != '0) begin
                                    n_row   = r_row - ROW_W'(1);
                                    n_col   = COL_W'(COLUMNS - 1);
                                    wr_en   = 1'b1;
                                    wr_addr = cur_addr - ADDR_W'(1);
                                end
                                fin = 1'b1;
                            end
                            CODE_FF: begin
                                n_state      = ST_SWEEP;
                                n_ptr        = top_base;
                                n_clear_mode = 1'b1;
                                n_row        = top_row;
                                n_col        = '0;
                            end
                            default: begin
                                fin = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_READ: begin
                n_res = r_rd_ok ? rd_data : '0;
                fin   = 1'b1;
            end
            ST_TAB: begin
                do_step   = 1'b1;
                n_tab_cnt = r_tab_cnt - TAB_W'(1);
            end
            ST_SWEEP: begin
                n_wr_pend  = 1'b1;
                n_wr_addr  = r_ptr;
                n_wr_blank = r_clear_mode || (32'(r_ptr) >= LAST_ROW_BASE);
                rd_en      = !n_wr_blank;
                rd_addr    = ADDR_W'(32'(r_ptr) + COLUMNS);
                if (32'(r_ptr) == CELLS - 1) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                if (r_after_tab && (r_tab_cnt != '0)) begin
                    n_state = ST_TAB;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_HOLD: begin
                fin = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (do_step) begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
            wr_data = {r_attr, step_char};
            if (col_last) begin
                n_col = '0;
                if (row_last) begin
                    scroll_start = 1'b1;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
            if (!scroll_start && ((r_state == ST_IDLE) || (r_tab_cnt == TAB_W'(1)))) begin
                fin = 1'b1;
            end
        end

        if (scroll_start) begin
            n_state      = ST_SWEEP;
            n_ptr        = top_base;
            n_clear_mode = 1'b0;
            n_row        = ROW_W'(ROWS - 1);
            n_col        = '0;
        end

        if (fin) begin
            n_state = slot_free ? ST_IDLE : ST_HOLD;
        end
    end

    assign pos_full = POS_W'(32'(n_row) * COLUMNS + 32'(n_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_row        <= ROW_W'(FIRST_ROW_RESET);
            r_col        <= '0;
            r_ptr        <= '0;
            r_tab_cnt    <= '0;
            r_clear_mode <= 1'b0;
            r_after_tab  <= 1'b0;
            r_rd_ok      <= 1'b0;
            r_wr_pend    <= 1'b0;
            r_attr       <= ATTR_RESET;
            r_first      <= FIRST_ROW_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_ptr        <= n_ptr;
            r_tab_cnt    <= n_tab_cnt;
            r_clear_mode <= n_clear_mode;
            r_after_tab  <= n_after_tab;
            r_rd_ok      <= n_rd_ok;
            r_wr_pend    <= n_wr_pend;
            r_res_data   <= n_res;
            r_wr_addr    <= n_wr_addr;
            r_wr_blank   <= n_wr_blank;
            if (i_cfg.valid) begin
                case (i_cfg.payload.index)
                    REG_CHAR_ATTRIBUTE: r_attr  <= ATTR_W'(i_cfg.payload.data);
                    REG_FIRST_TEXT_ROW: r_first <= FIRST_W'(i_cfg.payload.data);
                    default: begin
                    end
                endcase
            end
            if (fin && slot_free) begin
                r_out_valid                <= 1'b1;
                r_out_item.cursor_position <= pos_full;
                r_out_item.read_data       <= n_res;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `TCW_ASSERT_IMP(a_wr_in_range, wr_en, 32'(wr_addr) < CELLS, "Cell write outside the store.")
    `TCW_ASSERT_IMP(a_cursor_in_screen, 1'b1, (32'(r_row) < ROWS) && (32'(r_col) < COLUMNS), "Cursor left the screen.")
    `TCW_ASSERT_IMP(a_pend_in_sweep, r_wr_pend, (r_state == ST_SWEEP) || (r_state == ST_DRAIN), "Sweep write outside a sweep.")
    `TCW_ASSERT_NEXT(a_read_next, in_accept && (i_in.payload.op == OP_READ), r_state == ST_READ, "Read transfer did not start a read.")
    `TCW_ASSERT_NEXT(a_hold_when_full, fin && !slot_free, r_state == ST_HOLD, "Finished item lost while result waits.")

endmodule

FILE: hdl/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// Text console writer cell store
// Simple dual port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [CELL_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [CELL_W-1:0] o_rd_data
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
